// ----- rtl/core/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Command, status and cell operation codes, field widths, cell control bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_DUMP       = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // broadcast to every cell: what to do this cycle, and the value to
    // load (push) or compare against (search)
    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// ----- rtl/core/double_ended_queue_ring.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_ring: bounded deque of signed 32-bit values
// Chain of DEPTH cells; front entry sits in cell 0 except during a walk.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_valid/o_ready carries one command beat (i_command,
//   i_value). Output channel o_valid/i_ready carries result beats
//   (o_status, o_data, o_position, o_is_empty, o_last); o_last marks the
//   final result beat of a command.
//   Push, pop, clear and unused codes: one result, registered in the cycle
//   after the command beat; a new command is taken every cycle as long as
//   the result register is free or being drained the same cycle.
//   Search and dump: the chain rotates one cell per cycle unless the output
//   is stalled, visiting all entry_count entries (1 to DEPTH); the input is
//   held off until the walk is over. Search results appear as matches pass
//   the front cell; the last flag comes from a compare over the cells still
//   ahead. After the walk the chain is back in its original order.
//   Reset (synchronous, active low) empties the queue and clears the output
//   valid; cell contents are not reset.
//   A stalled receiver holds the result register and, during a walk,
//   freezes the rotation; nothing is dropped.
// ----------------------------------------------------------------------------
module double_ended_queue_ring #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [deq_pkg::CMD_W-1:0]           i_command,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [deq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [deq_pkg::DATA_W-1:0]   o_data,
    output logic [deq_pkg::POS_W-1:0]           o_position,
    output logic                                o_is_empty,
    output logic                                o_last
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // control
    t_state              r_state,  n_state;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [CNT_W-1:0]    r_rem,    n_rem;     // entries left to visit
    logic [CNT_W-1:0]    r_pos,    n_pos;     // 1-based position of cell 0
    logic                r_search, n_search;
    logic                r_found,  n_found;
    logic signed [DATA_W-1:0] r_key, n_key;

    // result register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic [CNT_W-1:0]    r_out_pos, n_out_pos;
    logic                r_out_empty, n_out_empty;
    logic                r_out_last, n_out_last;

    // chain
    t_cell_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_cell_data [DEPTH];
    logic signed [DATA_W-1:0] w_tail_data [DEPTH];
    logic                     w_later     [DEPTH];
    logic signed [DATA_W-1:0] w_tail;
    logic                     w_any_later;

    logic                w_out_free;
    logic                w_in_fire;
    logic                w_step;
    logic                w_full;
    logic                w_empty;
    logic                w_head_match;
    t_cmd                w_cmd;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_in_fire  = i_valid && o_ready;
    assign w_step     = (r_state == ST_WALK) && w_out_free;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_cmd      = t_cmd'(i_command);

    // ------------------------------------------------------------------
    // Cell chain: cell i sees i-1 as prev and i+1 as next
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;

        if (gi == 0) begin : g_first
            assign w_prev = w_cell_data[0];
        end else begin : g_mid
            assign w_prev = w_cell_data[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_end
            assign w_next = w_cell_data[gi];
        end else begin : g_inner
            assign w_next = w_cell_data[gi+1];
        end

        deq_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_rem         (r_rem),
            .i_prev        (w_prev),
            .i_next        (w_next),
            .i_head        (w_cell_data[0]),
            .o_data        (w_cell_data[gi]),
            .o_tail_data   (w_tail_data[gi]),
            .o_later_match (w_later[gi])
        );
    end

    // tail entry (for pop back) and "a match is still ahead" (for last flag)
    always_comb begin
        w_tail      = '0;
        w_any_later = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tail      = w_tail | w_tail_data[k];
            w_any_later = w_any_later | w_later[k];
        end
    end

    assign w_head_match = (w_cell_data[0] == r_key);

    // ------------------------------------------------------------------
    // Command decode, walk sequencing, result register load
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rem        = r_rem;
        n_pos        = r_pos;
        n_search     = r_search;
        n_found      = r_found;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_pos    = r_out_pos;
        n_out_empty  = r_out_empty;
        n_out_last   = r_out_last;
        w_ctl.op     = CELL_HOLD;
        w_ctl.value  = (r_state == ST_WALK) ? r_key : i_value;

        if (w_in_fire) begin
            // single-result commands: default to an ok beat with last set
            n_out_valid  = 1'b1;
            n_out_status = STAT_OK;
            n_out_data   = '0;
            n_out_pos    = '0;
            n_out_empty  = w_empty;
            n_out_last   = 1'b1;
            case (w_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_out_status = STAT_FULL;
                    end else begin
                        w_ctl.op    = (w_cmd == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                                : CELL_PUSH_BACK;
                        n_count     = r_count + 1'b1;
                        n_out_empty = 1'b0;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (w_empty) begin
                        n_out_status = STAT_EMPTY;
                    end else begin
                        if (w_cmd == CMD_POP_FRONT) begin
                            w_ctl.op   = CELL_POP_FRONT;
                            n_out_data = w_cell_data[0];
                        end else begin
                            n_out_data = w_tail;
                        end
                        n_count     = r_count - 1'b1;
                        n_out_empty = (r_count == CNT_W'(1));
                    end
                end
                CMD_SEARCH, CMD_DUMP: begin
                    if (w_empty) begin
                        n_out_status = STAT_EMPTY;
                    end else begin
                        n_out_valid = r_out_valid && !i_ready;
                        n_state     = ST_WALK;
                        n_rem       = r_count;
                        n_pos       = CNT_W'(1);
                        n_search    = (w_cmd == CMD_SEARCH);
                        n_found     = 1'b0;
                        n_key       = i_value;
                    end
                end
                CMD_CLEAR: begin
                    n_count     = '0;
                    n_out_empty = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (w_step) begin
            // one entry passes the front cell per step; chain rotates
            w_ctl.op = CELL_ROTATE;
            n_rem    = r_rem - 1'b1;
            n_pos    = r_pos + 1'b1;
            if (r_rem == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
            n_out_empty = 1'b0;
            n_out_pos   = r_pos;
            n_out_data  = w_cell_data[0];
            n_out_status = STAT_OK;
            if (!r_search) begin
                n_out_valid = 1'b1;
                n_out_last  = (r_rem == CNT_W'(1));
            end else if (w_head_match) begin
                n_out_valid = 1'b1;
                n_out_last  = !w_any_later;
                n_found     = 1'b1;
            end else if ((r_rem == CNT_W'(1)) && !r_found) begin
                n_out_valid  = 1'b1;
                n_out_status = STAT_NOT_FOUND;
                n_out_data   = '0;
                n_out_pos    = '0;
                n_out_last   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rem       <= '0;
            r_pos       <= '0;
            r_search    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_pos       <= n_pos;
            r_search    <= n_search;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_pos    <= n_out_pos;
        r_out_empty  <= n_out_empty;
        r_out_last   <= n_out_last;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_data     = r_out_data;
    assign o_position = POS_W'(r_out_pos);
    assign o_is_empty = r_out_empty;
    assign o_last     = r_out_last;

endmodule

// ----- rtl/core/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell: one storage slot of the queue chain
// Holds one entry; loads, keeps, or takes another cell's entry each cycle.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                                i_clk,
    input  deq_pkg::t_cell_ctl                  i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]          i_count,
    input  logic [$clog2(DEPTH+1)-1:0]          i_rem,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_prev,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_next,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_head,
    output logic signed [deq_pkg::DATA_W-1:0]   o_data,
    output logic signed [deq_pkg::DATA_W-1:0]   o_tail_data,
    output logic                                o_later_match
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_is_slot;
    logic                     w_is_tail;
    logic                     w_is_later;

    assign w_is_slot  = (i_count == CNT_W'(IDX));
    assign w_is_tail  = (i_count == CNT_W'(IDX + 1));
    // cell still ahead in the walk, not counting the front cell
    assign w_is_later = (IDX != 0) && (CNT_W'(IDX) < i_rem);

    always_comb begin
        case (i_ctl.op)
            CELL_HOLD:       n_data = r_data;
            CELL_PUSH_FRONT: n_data = (IDX == 0) ? i_ctl.value : i_prev;
            CELL_PUSH_BACK:  n_data = w_is_slot ? i_ctl.value : r_data;
            CELL_POP_FRONT:  n_data = i_next;
            CELL_ROTATE:     n_data = w_is_tail ? i_head : i_next;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data        = r_data;
    assign o_tail_data   = w_is_tail ? r_data : '0;
    assign o_later_match = w_is_later && (r_data == i_ctl.value);

endmodule

// ----- rtl/core/deq_checker.sv -----
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [deq_pkg::STATUS_W-1:0]        o_status,
    input logic signed [deq_pkg::DATA_W-1:0]   o_data,
    input logic [deq_pkg::POS_W-1:0]           o_position,
    input logic                                o_is_empty,
    input logic                                o_last
);
    import deq_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data) && $stable(o_last)
                                && $stable(o_status) && $stable(o_position))
        else $error("result beat changed while stalled");

    // mid-walk results keep the input closed
    a_walk_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input open while a walk is still running");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_EMPTY) |-> o_is_empty && o_last)
        else $error("empty status without empty flag or last");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_NOT_FOUND)
            |-> o_last && (o_position == '0) && !o_is_empty)
        else $error("bad not-found beat");

    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_FULL) |-> !o_is_empty && o_last)
        else $error("full status on an empty queue");

endmodule

bind double_ended_queue_ring deq_checker u_deq_checker (.*);
